FILE: hw/rtl/xs1024_pkg.sv
// Shared types and constants for the xorshift1024* generator core.
// Used by the top level, the product pipeline and the result queue.
package xs1024_pkg;

  localparam int WORD_W  = 64;
  localparam int HALF_W  = 32;
  localparam int POS_W   = 4;
  localparam int MODE_W  = 2;
  localparam int NUM_WORDS = 16;

  // Default depth of the result queue; six entries cover the pipeline at full rate.
  localparam int XS_FIFO_DEPTH = 8;

  // Multiplier of the xorshift1024* output stage.
  localparam logic [WORD_W-1:0] XS_MULT = 64'h1066_89D4_5497_FDB5;

  // Xorshift shift amounts.
  localparam int SHIFT_A = 31;
  localparam int SHIFT_B = 11;
  localparam int SHIFT_C = 30;

  typedef enum logic [MODE_W-1:0] {
    MODE_GEN  = 2'd0,
    MODE_LOAD = 2'd1,
    MODE_SET  = 2'd2
  } mode_t;

  // Control that travels beside a word through the product pipeline.
  typedef struct packed {
    logic             valid;
    logic             gen;
    logic [POS_W-1:0] pos;
  } ctrl_t;

  typedef struct packed {
    logic [WORD_W-1:0] random_word;
    logic [WORD_W-1:0] unit_fraction;
    logic [POS_W-1:0]  position;
  } result_t;

endpackage

FILE: hw/rtl/xs1024_mul.sv
// Two-stage 64 x 64 multiplier by the fixed xorshift1024* constant, modulo 2^64.
// Depends on xs1024_pkg for widths, the constant and the control struct.
module xs1024_mul (
  input  logic                           clk,
  input  logic                           rst,
  input  xs1024_pkg::ctrl_t              in_ctrl,
  input  logic [xs1024_pkg::WORD_W-1:0]  in_word,
  output xs1024_pkg::ctrl_t              out_ctrl,
  output logic [xs1024_pkg::WORD_W-1:0]  out_product,
  output logic [1:0]                     busy_count
);
  import xs1024_pkg::*;

  localparam logic [HALF_W-1:0] MULT_LO = XS_MULT[HALF_W-1:0];
  localparam logic [HALF_W-1:0] MULT_HI = XS_MULT[WORD_W-1:HALF_W];

  ctrl_t             ctrl_a;
  logic [WORD_W-1:0] prod_ll;
  logic [HALF_W-1:0] prod_lh;
  logic [HALF_W-1:0] prod_hl;
  logic [WORD_W-1:0] full_ll;
  logic [WORD_W-1:0] full_lh;
  logic [WORD_W-1:0] full_hl;
  logic [HALF_W-1:0] cross_sum;

  // Only the low half of each cross product reaches bits below 2^64.
  assign full_ll = {{HALF_W{1'b0}}, in_word[HALF_W-1:0]} * {{HALF_W{1'b0}}, MULT_LO};
  assign full_lh = {{HALF_W{1'b0}}, in_word[HALF_W-1:0]} * {{HALF_W{1'b0}}, MULT_HI};
  assign full_hl = {{HALF_W{1'b0}}, in_word[WORD_W-1:HALF_W]} * {{HALF_W{1'b0}}, MULT_LO};

  always_ff @(posedge clk) begin
    prod_ll <= full_ll;
    prod_lh <= full_lh[HALF_W-1:0];
    prod_hl <= full_hl[HALF_W-1:0];
    ctrl_a.gen <= in_ctrl.gen;
    ctrl_a.pos <= in_ctrl.pos;
    if (rst) begin
      ctrl_a.valid <= 1'b0;
    end else begin
      ctrl_a.valid <= in_ctrl.valid;
    end
  end

  assign cross_sum = prod_lh + prod_hl;

  always_ff @(posedge clk) begin
    out_product  <= prod_ll + {cross_sum, {HALF_W{1'b0}}};
    out_ctrl.gen <= ctrl_a.gen;
    out_ctrl.pos <= ctrl_a.pos;
    if (rst) begin
      out_ctrl.valid <= 1'b0;
    end else begin
      out_ctrl.valid <= ctrl_a.valid;
    end
  end

  assign busy_count = {1'b0, ctrl_a.valid} + {1'b0, out_ctrl.valid};

endmodule

FILE: hw/rtl/xs1024_fifo.sv
// Result queue between the product pipeline and the output channel.
// Depends on xs1024_pkg for the result struct.
module xs1024_fifo #(
  parameter int Depth = xs1024_pkg::XS_FIFO_DEPTH
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  input  xs1024_pkg::result_t          push_data,
  input  logic                         pop,
  output xs1024_pkg::result_t          head,
  output logic [$clog2(Depth+1)-1:0]   count
);
  import xs1024_pkg::*;

  localparam int PTR_W = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CNT_W = $clog2(Depth+1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(Depth - 1);

  result_t          entries [Depth];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == LAST) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == LAST) ? '0 : rptr + 1'b1;
      end
      count <= count + CNT_W'(push) - CNT_W'(pop);
    end
  end

  assign head = entries[rptr];

endmodule

FILE: hw/rtl/xorshift1024_star_generator_core.sv
// xorshift1024* generator core: sixteen state words in a synchronous memory,
// a read-modify-write stage with forwarding, a multiplier pipeline and a result queue.
// Depends on xs1024_pkg, xs1024_mul and xs1024_fifo.
//
// The core takes one item per clock cycle while in_stall is low and gives exactly
// one result item for each item taken, in order. A generate item returns the next
// xorshift1024* number and that number with its top bit flipped, as an unsigned
// fraction over 2^64; a load item writes one seed word and a set item moves the
// position, both returning zero words and the position. On its way to the output
// an item reads the memory at the edge that takes it, then passes the mix and
// write-back, the 64-bit product, built from three 32 x 32 partial products, and
// the write into the result queue. Sustained throughput is one item per cycle
// while the output does not stall, set by the single write port of the state
// memory, which every item uses at most once. Results wait in a queue of FifoDepth
// entries; the input stalls whenever the queue together with the items still in
// flight could fill it. Seed words have no reset: every word that a generate
// item will read must first be loaded.
module xorshift1024_star_generator_core #(
  parameter int FifoDepth = xs1024_pkg::XS_FIFO_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [xs1024_pkg::MODE_W-1:0]  mode,
  input  logic [xs1024_pkg::POS_W-1:0]   word_index,
  input  logic [xs1024_pkg::WORD_W-1:0]  seed_value,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [xs1024_pkg::WORD_W-1:0]  random_word,
  output logic [xs1024_pkg::WORD_W-1:0]  unit_fraction,
  output logic [xs1024_pkg::POS_W-1:0]   position
);
  import xs1024_pkg::*;

  localparam int CNT_W = $clog2(FifoDepth+1);
  localparam int SUM_W = CNT_W + 2;
  localparam logic [WORD_W-1:0] TOP_BIT = {1'b1, {(WORD_W-1){1'b0}}};

  // State memory: no reset, a word is defined once it has been loaded.
  logic [WORD_W-1:0] words [NUM_WORDS];

  logic              accept;
  logic [POS_W-1:0]  pos;
  logic [POS_W-1:0]  pos_next;
  logic [POS_W-1:0]  pos_inc;

  // Read stage registers.
  logic [WORD_W-1:0] rdata0;
  logic [WORD_W-1:0] rdata1;
  logic [POS_W-1:0]  addr0;
  logic [POS_W-1:0]  addr1;
  logic              v1;
  logic [MODE_W-1:0] mode1;
  logic [POS_W-1:0]  idx1;
  logic [WORD_W-1:0] seed1;
  logic [POS_W-1:0]  pos1;

  // Copy of the write made at the most recent edge, for forwarding.
  logic              lw_valid;
  logic [POS_W-1:0]  lw_addr;
  logic [WORD_W-1:0] lw_data;

  logic [WORD_W-1:0] s0w;
  logic [WORD_W-1:0] s1w;
  logic [WORD_W-1:0] t1a;
  logic [WORD_W-1:0] t1b;
  logic [WORD_W-1:0] t0;
  logic [WORD_W-1:0] mix;
  logic              is_gen1;
  logic              wr_en;
  logic [POS_W-1:0]  wr_addr;
  logic [WORD_W-1:0] wr_data;

  ctrl_t             ctrl2;
  logic [WORD_W-1:0] mix2;
  ctrl_t             ctrl_out;
  logic [WORD_W-1:0] product;
  logic [1:0]        mul_busy;

  result_t           push_data;
  result_t           head;
  logic [CNT_W-1:0]  q_count;
  logic              pop;
  logic [SUM_W-1:0]  in_flight;

  assign accept  = in_valid && !in_stall;
  assign pos_inc = pos + 1'b1;

  // The position moves as soon as an item is taken, so the next item reads
  // from the right place without waiting for this one.
  always_comb begin
    pos_next = pos;
    if (accept) begin
      case (mode)
        MODE_GEN: pos_next = pos_inc;
        MODE_SET: pos_next = word_index;
        default:  pos_next = pos;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else begin
      pos <= pos_next;
    end
  end

  // Memory: both reads every cycle, one write from the modify stage.
  always_ff @(posedge clk) begin
    rdata0 <= words[pos];
    rdata1 <= words[pos_inc];
    if (wr_en) begin
      words[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    addr0 <= pos;
    addr1 <= pos_inc;
    mode1 <= mode;
    idx1  <= word_index;
    seed1 <= seed_value;
    pos1  <= pos_next;
    lw_addr <= wr_addr;
    lw_data <= wr_data;
    if (rst) begin
      v1       <= 1'b0;
      lw_valid <= 1'b0;
    end else begin
      v1       <= accept;
      lw_valid <= wr_en;
    end
  end

  // A write that landed at the same edge as the read is not yet visible in the
  // read data; every earlier write is, so one forwarding register suffices.
  assign s0w = (lw_valid && lw_addr == addr0) ? lw_data : rdata0;
  assign s1w = (lw_valid && lw_addr == addr1) ? lw_data : rdata1;

  assign t1a = s1w ^ (s1w << SHIFT_A);
  assign t1b = t1a ^ (t1a >> SHIFT_B);
  assign t0  = s0w ^ (s0w >> SHIFT_C);
  assign mix = t0 ^ t1b;

  assign is_gen1 = (mode1 == MODE_GEN);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx1;
    wr_data = seed1;
    case (mode1)
      MODE_GEN: begin
        wr_en   = v1;
        wr_addr = pos1;
        wr_data = mix;
      end
      MODE_LOAD: begin
        wr_en = v1;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // Non-generate items carry a zero word, so their product is zero too.
  always_ff @(posedge clk) begin
    mix2      <= is_gen1 ? mix : '0;
    ctrl2.gen <= is_gen1;
    ctrl2.pos <= pos1;
    if (rst) begin
      ctrl2.valid <= 1'b0;
    end else begin
      ctrl2.valid <= v1;
    end
  end

  xs1024_mul u_mul (
    .clk         (clk),
    .rst         (rst),
    .in_ctrl     (ctrl2),
    .in_word     (mix2),
    .out_ctrl    (ctrl_out),
    .out_product (product),
    .busy_count  (mul_busy)
  );

  // Flipping the top bit turns the two's complement value into an offset fraction.
  assign push_data.random_word   = product;
  assign push_data.unit_fraction = ctrl_out.gen ? (product ^ TOP_BIT) : '0;
  assign push_data.position      = ctrl_out.pos;

  xs1024_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (ctrl_out.valid),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .count     (q_count)
  );

  assign out_valid     = (q_count != '0);
  assign pop           = out_valid && !out_stall;
  assign random_word   = head.random_word;
  assign unit_fraction = head.unit_fraction;
  assign position      = head.position;

  // Every item in the pipeline has a queue entry reserved for it, so the queue
  // cannot overflow however long the output stalls.
  assign in_flight = SUM_W'(q_count) + SUM_W'(v1) + SUM_W'(ctrl2.valid) + SUM_W'(mul_busy);
  assign in_stall  = (in_flight >= SUM_W'(FifoDepth));

endmodule

FILE: dv/tb_top.sv
// Self-checking testbench for the xorshift1024* generator core.
// Depends on xs1024_pkg and on the RTL of xorshift1024_star_generator_core.
// A built-in predictor checks every result item against the number it should carry.
module tb_top;
  import xs1024_pkg::*;

  // The fourth mode code is not in the package enum; the core changes nothing for it but still returns a result.
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
  localparam logic [WORD_W-1:0] TOP_BIT = {1'b1, {(WORD_W-1){1'b0}}};

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [MODE_W-1:0] mode = MODE_GEN;
  logic [POS_W-1:0]  word_index = '0;
  logic [WORD_W-1:0] seed_value = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [WORD_W-1:0] random_word;
  logic [WORD_W-1:0] unit_fraction;
  logic [POS_W-1:0]  position;

  // Predictor state: a private copy of the sixteen words and the position, plus a
  // record of which words have been written since reset, so that no generate item
  // ever reads a word that the core has not been given.
  logic [WORD_W-1:0] gen_words [NUM_WORDS];
  logic [POS_W-1:0]  gen_pos = '0;
  logic [NUM_WORDS-1:0] word_loaded = '0;

  // Results that the core still owes, oldest first.
  result_t predicted_results[$];

  int error_count = 0;
  bit idle_on = 1'b1;    // random gaps on both sides when set
  int hold_cycles = 0;   // long output hold-off, counted down by the checker

  always #10 clk = ~clk;

  xorshift1024_star_generator_core u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .mode         (mode),
    .word_index   (word_index),
    .seed_value   (seed_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .random_word  (random_word),
    .unit_fraction(unit_fraction),
    .position     (position)
  );

  // Advances the private generator by one accepted item and returns the result
  // item that the core must give for it.
  function automatic result_t advance_generator(logic [MODE_W-1:0] m, logic [POS_W-1:0] idx,
                                                logic [WORD_W-1:0] seed);
    result_t r;
    logic [WORD_W-1:0] s0, s1, mixed;
    logic [POS_W-1:0] nxt;
    r = '0;
    case (m)
      MODE_GEN: begin
        nxt = gen_pos + 1'b1;
        s0 = gen_words[gen_pos];
        s1 = gen_words[nxt];
        s1 = s1 ^ (s1 << SHIFT_A);
        s1 = s1 ^ (s1 >> SHIFT_B);
        s0 = s0 ^ (s0 >> SHIFT_C);
        mixed = s0 ^ s1;
        gen_words[nxt] = mixed;
        word_loaded[nxt] = 1'b1;
        gen_pos = nxt;
        r.random_word = mixed * XS_MULT;
        // Flipping the top bit turns the signed value into a fraction in [0,1).
        r.unit_fraction = r.random_word ^ TOP_BIT;
      end
      MODE_LOAD: begin
        gen_words[idx] = seed;
        word_loaded[idx] = 1'b1;
      end
      MODE_SET: gen_pos = idx;
      default: ;
    endcase
    r.position = gen_pos;
    return r;
  endfunction

  // Offers one item, after a random gap when idle_on is set, and holds it until the
  // core takes it. The valid is left high on return, so a following item with no gap
  // only changes the payload and never drops valid for a moment.
  task automatic send_item(logic [MODE_W-1:0] m, logic [POS_W-1:0] idx,
                           logic [WORD_W-1:0] seed);
    int gap;
    gap = idle_on ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    mode       <= m;
    word_index <= idx;
    seed_value <= seed;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted_results.push_back(advance_generator(m, idx, seed));
  endtask

  // Drops valid and waits until the core has given every result owed, with a bound.
  task automatic wait_for_results();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (predicted_results.size() != 0 && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
  endtask

  // Seeds are mostly uniform, with the extremes and single set bits mixed in.
  function automatic logic [WORD_W-1:0] draw_seed();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return '1;
      2:       return 64'd1 << $urandom_range(0, WORD_W - 1);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // One random item. A generate item is only sent when both words that it reads
  // have been written; otherwise the missing word is loaded instead.
  task automatic send_random_item();
    int pick;
    logic [MODE_W-1:0] m;
    logic [POS_W-1:0] idx, nxt;
    pick = $urandom_range(0, 99);
    idx = POS_W'($urandom);
    nxt = gen_pos + 1'b1;
    if (pick < 70) begin
      m = MODE_GEN;
    end else if (pick < 82) begin
      m = MODE_LOAD;
    end else if (pick < 94) begin
      m = MODE_SET;
    end else begin
      m = MODE_SPARE;
    end
    if (m == MODE_GEN && !(word_loaded[gen_pos] && word_loaded[nxt])) begin
      m = MODE_LOAD;
      idx = word_loaded[gen_pos] ? nxt : gen_pos;
    end
    send_item(m, idx, draw_seed());
  endtask

  // Right after reset the position is zero and nothing is loaded: an ignored
  // item and position moves must report the position with zero words.
  task automatic test_after_reset();
    send_item(MODE_SPARE, 4'hF, '1);
    send_item(MODE_SET, 4'hF, '0);
    send_item(MODE_SET, 4'h0, '1);
    send_item(MODE_SET, 4'hF, '0);
  endtask

  // Extremes of the seed, the wrap of the position from fifteen to zero, the
  // all-zero word pair and generate items straight after the load they read,
  // all back to back so that the write-back forwarding is exercised.
  task automatic test_directed_cases();
    idle_on = 1'b0;
    send_item(MODE_LOAD, 4'hF, '1);
    send_item(MODE_LOAD, 4'h0, '0);
    send_item(MODE_GEN, 4'h0, '0);       // reads words fifteen and zero
    send_item(MODE_LOAD, 4'h1, '0);
    send_item(MODE_SET, 4'h0, '0);
    send_item(MODE_LOAD, 4'h0, '0);
    send_item(MODE_GEN, 4'h0, '0);       // both words zero, so the result is zero
    send_item(MODE_LOAD, 4'h2, 64'd1);
    send_item(MODE_GEN, 4'h0, '0);
    send_item(MODE_LOAD, 4'h3, {32'hDEAD_BEEF, 32'h0123_4567});
    send_item(MODE_GEN, 4'h0, '0);
    send_item(MODE_LOAD, 4'h4, TOP_BIT);
    send_item(MODE_GEN, 4'h0, '0);
    send_item(MODE_SPARE, 4'h0, '1);     // ignored between generates
    send_item(MODE_LOAD, 4'h6, {32'h0F0F_0F0F, 32'hF0F0_F0F0});
    send_item(MODE_LOAD, 4'h5, '1);
    send_item(MODE_GEN, 4'h0, '0);
    send_item(MODE_GEN, 4'h0, '0);       // reads the word the previous item wrote
    idle_on = 1'b1;
  endtask

  // Loads every word so that the random stream can generate from any position.
  task automatic test_full_seed();
    for (int i = 0; i < NUM_WORDS; i++) begin
      send_item(MODE_LOAD, POS_W'(i), draw_seed());
    end
  endtask

  task automatic test_random_stream(int count, bit with_gaps);
    idle_on = with_gaps;
    repeat (count) send_random_item();
    idle_on = 1'b1;
  endtask

  // The receiver holds off for a long stretch while items keep coming, so the
  // result queue fills and the core has to stall its input.
  task automatic test_output_hold();
    hold_cycles = 120;
    idle_on = 1'b0;
    repeat (60) send_random_item();
    idle_on = 1'b1;
  endtask

  // The sender stops until every result has come, then resumes.
  task automatic test_sender_pause();
    wait_for_results();
    test_random_stream(280, 1'b1);
  endtask

  // Result checker: compares each accepted result item with the oldest
  // prediction, then draws how long to hold off before the next one.
  initial begin : result_checker
    int rx_wait;
    result_t want;
    rx_wait = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        if (predicted_results.size() == 0) begin
          $error("unexpected result: random_word %h, position %h", random_word, position);
          error_count++;
        end else begin
          want = predicted_results.pop_front();
          if (random_word !== want.random_word) begin
            $error("random_word: expected %h, got %h", want.random_word, random_word);
            error_count++;
          end
          if (unit_fraction !== want.unit_fraction) begin
            $error("unit_fraction: expected %h, got %h", want.unit_fraction, unit_fraction);
            error_count++;
          end
          if (position !== want.position) begin
            $error("position: expected %h, got %h", want.position, position);
            error_count++;
          end
        end
        rx_wait = idle_on ? $urandom_range(0, 3) : 0;
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_stall <= 1'b1;
      end else if (rx_wait > 0) begin
        rx_wait--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Test sequence: one reset, the directed cases, a full seed load, then the random phases.
  initial begin
    for (int i = 0; i < NUM_WORDS; i++) gen_words[i] = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_after_reset();
    test_directed_cases();
    test_full_seed();
    test_random_stream(300, 1'b1);
    test_random_stream(200, 1'b0);
    test_output_hold();
    test_sender_pause();
    wait_for_results();
    // Wait on after the queue empties, so that any stray result is seen.
    repeat (16) @(posedge clk);
    if (predicted_results.size() != 0) begin
      $error("%0d expected results never arrived", predicted_results.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog far beyond the slowest correct run.
  initial begin
    #4000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
